@@ rtl/swtq_pkg.sv @@
// ----------------------------------------------------------------------------
// swtq_pkg
// Shared types and codes for the sorted wakeup timer queue.
// ----------------------------------------------------------------------------
package swtq_pkg;

    // request kinds carried on the input tuser
    localparam logic [1:0] REQ_ADD     = 2'd0;
    localparam logic [1:0] REQ_REMOVE  = 2'd1;
    localparam logic [1:0] REQ_TIMEOUT = 2'd2;
    localparam logic [1:0] REQ_WRAP    = 2'd3;

    // final status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TIMED_OUT = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic [7:0]  proc;
        logic [31:0] wake;
        logic [15:0] wraps;
    } slot_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_ADD_FREE,
        S_INS_RD,
        S_INS_SLOT,
        S_INS_CMP,
        S_INS_PUT,
        S_WAKE_RD,
        S_WAKE_SLOT,
        S_WAKE_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_REM_RD,
        S_REM_SLOT,
        S_REM_CMP,
        S_WRAP_RD,
        S_WRAP_SLOT,
        S_WRAP_CMP,
        S_STATUS
    } state_t;

endpackage

@@ rtl/sorted_wakeup_timer_queue.sv @@
// ----------------------------------------------------------------------------
// sorted_wakeup_timer_queue
// Sorted queue of sleeping process ids for a down-counting system timer.
// ----------------------------------------------------------------------------
// Steps: each entry walked takes an order read, a slot read and a compare; a
//   free-slot scan tests the slots in turn, a drop at position p closes the gap
//   by shifting later order entries toward the head, and an insert ends in a write.
// Throughput: one request at a time; the next is taken after the status beat
//   loads, and result stalls hold the walk. Reset: async; clears control,
//   valid bits and count only.
module sorted_wakeup_timer_queue #(
    parameter int MAX_WAITERS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // input request beat
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,  // proc_id[7:0], wake_time[39:8], wraps_left[55:40], now[87:56]
    input  logic [1:0]  s_tuser,  // req_type[1:0]
    // result beat
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,  // woken_id[7:0], status[9:8], timer_update[10],
                                  // compare_enable[11], compare_value[43:12], zero[47:44]
    output logic        m_tuser,  // is_status
    output logic        m_tlast   // last
);

    import swtq_pkg::*;

    localparam int IW = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
    localparam int CW = $clog2(MAX_WAITERS + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_WAITERS);
    localparam logic [CW-1:0] ONE     = CW'(1);

    state_t state_reg, state_next;

    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] k_reg, k_next;       // walk position
    logic [CW-1:0] j_reg, j_next;       // free scan / wrap write position
    logic [IW-1:0] free_reg, free_next;
    logic [IW-1:0] cur_reg, cur_next;   // slot index taken from the order list
    logic [1:0]    req_reg, req_next;
    logic [7:0]    id_reg, id_next;
    logic [31:0]   wake_reg, wake_next;
    logic [15:0]   wraps_reg, wraps_next;
    logic [31:0]   now_reg, now_next;
    logic [1:0]    stat_reg, stat_next;
    logic          en_reg, en_next;
    logic [31:0]   val_reg, val_next;

    logic valid_reg [MAX_WAITERS];

    // memory ports
    logic          ord_we, ord_re;
    logic [IW-1:0] ord_waddr, ord_raddr, ord_wdata, ord_q;
    logic          slot_we, slot_re;
    logic [IW-1:0] slot_waddr, slot_raddr;
    slot_t         slot_wdata, slot_q;

    // control
    logic          in_acc, out_free;
    logic          valid_set, valid_clr;
    logic [IW-1:0] valid_idx;
    logic          out_load, out_woken;

    logic [7:0]    in_id;
    logic [31:0]   in_wake, in_now;
    logic [15:0]   in_wraps;

    logic          goes_after, is_due, last_shift, walk_end, upd_calc;
    logic [CW-1:0] k_inc, j_wrap;

    // output register
    logic        out_valid_reg;
    logic        out_user_reg, out_last_reg, out_upd_reg, out_en_reg;
    logic [7:0]  out_id_reg;
    logic [1:0]  out_stat_reg;
    logic [31:0] out_val_reg;

    assign in_id    = s_tdata[7:0];
    assign in_wake  = s_tdata[39:8];
    assign in_wraps = s_tdata[55:40];
    assign in_now   = s_tdata[87:56];

    assign s_tready = (state_reg == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    assign k_inc      = k_reg + ONE;
    // the walked entry sorts strictly after the new one
    assign goes_after = (slot_q.wraps > wraps_reg) ||
                        ((slot_q.wraps == wraps_reg) && (slot_q.wake < wake_reg));
    assign is_due     = (slot_q.wraps == 16'd0) && (slot_q.wake >= now_reg);
    assign last_shift = (k_inc >= cnt_reg);
    assign walk_end   = (k_inc == cnt_reg);
    assign j_wrap     = j_reg + ((slot_q.wraps != 16'd0) ? ONE : '0);
    assign upd_calc   = (req_reg != REQ_REMOVE) && (stat_reg != ST_TIMED_OUT);

    swtq_ram #(.WIDTH(IW), .DEPTH(MAX_WAITERS)) u_order (
        .clk   (clk),
        .we    (ord_we),
        .waddr (ord_waddr),
        .wdata (ord_wdata),
        .re    (ord_re),
        .raddr (ord_raddr),
        .rdata (ord_q)
    );

    swtq_ram #(.WIDTH($bits(slot_t)), .DEPTH(MAX_WAITERS)) u_slot (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .re    (slot_re),
        .raddr (slot_raddr),
        .rdata (slot_q)
    );

    // ---------------------------------------------------------------- next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    case (s_tuser)
                        REQ_ADD:
                        begin
                            if (in_wake > in_now)
                                state_next = S_STATUS;
                            else if (cnt_reg == CNT_MAX)
                                state_next = S_WAKE_RD;
                            else
                                state_next = S_ADD_FREE;
                        end
                        REQ_REMOVE:  state_next = (cnt_reg == '0) ? S_STATUS : S_REM_RD;
                        REQ_TIMEOUT: state_next = S_WAKE_RD;
                        default:     state_next = (cnt_reg == '0) ? S_WAKE_RD : S_WRAP_RD;
                    endcase
                end
            end
            S_ADD_FREE:
            begin
                if (!valid_reg[j_reg[IW-1:0]])
                    state_next = (cnt_reg == '0) ? S_INS_PUT : S_INS_RD;
            end
            S_INS_RD:   state_next = S_INS_SLOT;
            S_INS_SLOT: state_next = S_INS_CMP;
            S_INS_CMP:
            begin
                if (goes_after && (k_reg != ONE))
                    state_next = S_INS_RD;
                else
                    state_next = S_INS_PUT;
            end
            S_INS_PUT:  state_next = S_WAKE_RD;
            S_WAKE_RD:  state_next = (cnt_reg == '0) ? S_STATUS : S_WAKE_SLOT;
            S_WAKE_SLOT: state_next = S_WAKE_CMP;
            S_WAKE_CMP:
            begin
                if (!is_due)
                    state_next = S_STATUS;
                else if (out_free)
                    state_next = S_SHIFT_RD;
            end
            S_SHIFT_RD:
            begin
                if (last_shift)
                    state_next = (req_reg == REQ_REMOVE) ? S_STATUS : S_WAKE_RD;
                else
                    state_next = S_SHIFT_WR;
            end
            S_SHIFT_WR: state_next = S_SHIFT_RD;
            S_REM_RD:   state_next = S_REM_SLOT;
            S_REM_SLOT: state_next = S_REM_CMP;
            S_REM_CMP:
            begin
                if (slot_q.proc == id_reg)
                    state_next = S_SHIFT_RD;
                else if (walk_end)
                    state_next = S_STATUS;
                else
                    state_next = S_REM_RD;
            end
            S_WRAP_RD:   state_next = S_WRAP_SLOT;
            S_WRAP_SLOT: state_next = S_WRAP_CMP;
            S_WRAP_CMP:
            begin
                if ((slot_q.wraps != 16'd0) || out_free)
                    state_next = walk_end ? S_WAKE_RD : S_WRAP_RD;
            end
            S_STATUS:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // ---------------------------------------------------- memory and beat control
    always_comb
    begin
        ord_re     = 1'b0;
        ord_raddr  = k_reg[IW-1:0];
        ord_we     = 1'b0;
        ord_waddr  = k_reg[IW-1:0];
        ord_wdata  = cur_reg;
        slot_re    = 1'b0;
        slot_raddr = ord_q;
        slot_we    = 1'b0;
        slot_waddr = cur_reg;
        slot_wdata = slot_q;
        slot_wdata.wraps = slot_q.wraps - 16'd1;
        valid_set  = 1'b0;
        valid_clr  = 1'b0;
        valid_idx  = cur_reg;
        out_load   = 1'b0;
        out_woken  = 1'b0;
        case (state_reg)
            S_INS_RD:
            begin
                ord_re    = 1'b1;
                ord_raddr = IW'(k_reg - ONE);
            end
            S_INS_SLOT: slot_re = 1'b1;
            S_INS_CMP:
            begin
                // open the hole one place further toward the head
                ord_we = goes_after;
            end
            S_INS_PUT:
            begin
                ord_we     = 1'b1;
                ord_wdata  = free_reg;
                slot_we    = 1'b1;
                slot_waddr = free_reg;
                slot_wdata = '{proc: id_reg, wake: wake_reg, wraps: wraps_reg};
                valid_set  = 1'b1;
                valid_idx  = free_reg;
            end
            S_WAKE_RD:
            begin
                ord_re    = (cnt_reg != '0);
                ord_raddr = '0;
            end
            S_WAKE_SLOT: slot_re = 1'b1;
            S_WAKE_CMP:
            begin
                if (is_due && out_free)
                begin
                    out_load  = 1'b1;
                    out_woken = 1'b1;
                    valid_clr = 1'b1;
                end
            end
            S_SHIFT_RD:
            begin
                ord_re    = !last_shift;
                ord_raddr = k_inc[IW-1:0];
            end
            S_SHIFT_WR:
            begin
                ord_we    = 1'b1;
                ord_wdata = ord_q;
            end
            S_REM_RD:   ord_re = 1'b1;
            S_REM_SLOT: slot_re = 1'b1;
            S_REM_CMP:  valid_clr = (slot_q.proc == id_reg);
            S_WRAP_RD:  ord_re = 1'b1;
            S_WRAP_SLOT: slot_re = 1'b1;
            S_WRAP_CMP:
            begin
                if (slot_q.wraps != 16'd0)
                begin
                    // decrement and compact toward the head
                    slot_we   = 1'b1;
                    ord_we    = 1'b1;
                    ord_waddr = j_reg[IW-1:0];
                end
                else if (out_free)
                begin
                    out_load  = 1'b1;
                    out_woken = 1'b1;
                    valid_clr = 1'b1;
                end
            end
            S_STATUS:   out_load = out_free;
            default:
            begin
                out_load = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------- datapath next
    always_comb
    begin
        cnt_next   = cnt_reg;
        k_next     = k_reg;
        j_next     = j_reg;
        free_next  = free_reg;
        cur_next   = cur_reg;
        req_next   = req_reg;
        id_next    = id_reg;
        wake_next  = wake_reg;
        wraps_next = wraps_reg;
        now_next   = now_reg;
        stat_next  = stat_reg;
        en_next    = en_reg;
        val_next   = val_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    req_next   = s_tuser;
                    id_next    = in_id;
                    wake_next  = in_wake;
                    wraps_next = in_wraps;
                    now_next   = in_now;
                    k_next     = '0;
                    j_next     = '0;
                    en_next    = 1'b0;
                    val_next   = '0;
                    stat_next  = ST_OK;
                    if ((s_tuser == REQ_ADD) && (in_wake > in_now))
                        stat_next = ST_TIMED_OUT;
                    if ((s_tuser == REQ_REMOVE) && (cnt_reg == '0))
                        stat_next = ST_NOT_FOUND;
                end
            end
            S_ADD_FREE:
            begin
                if (valid_reg[j_reg[IW-1:0]])
                    j_next = j_reg + ONE;
                else
                begin
                    free_next = j_reg[IW-1:0];
                    k_next    = cnt_reg;
                end
            end
            S_INS_SLOT, S_WAKE_SLOT, S_REM_SLOT, S_WRAP_SLOT: cur_next = ord_q;
            S_INS_CMP:
            begin
                if (goes_after)
                    k_next = k_reg - ONE;
            end
            S_INS_PUT:  cnt_next = cnt_reg + ONE;
            S_WAKE_RD:
            begin
                k_next = '0;
                if (cnt_reg == '0)
                begin
                    en_next  = 1'b0;
                    val_next = '0;
                end
            end
            S_WAKE_CMP:
            begin
                if (!is_due)
                begin
                    en_next  = (slot_q.wraps == 16'd0);
                    val_next = slot_q.wake;
                end
            end
            S_SHIFT_RD:
            begin
                if (last_shift)
                    cnt_next = cnt_reg - ONE;
            end
            S_SHIFT_WR: k_next = k_inc;
            S_REM_CMP:
            begin
                if (slot_q.proc != id_reg)
                begin
                    k_next = k_inc;
                    if (walk_end)
                        stat_next = ST_NOT_FOUND;
                end
            end
            S_WRAP_CMP:
            begin
                if ((slot_q.wraps != 16'd0) || out_free)
                begin
                    j_next = j_wrap;
                    k_next = k_inc;
                    if (walk_end)
                        cnt_next = j_wrap;
                end
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            k_reg     <= '0;
            j_reg     <= '0;
            req_reg   <= REQ_ADD;
            stat_reg  <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            k_reg     <= k_next;
            j_reg     <= j_next;
            req_reg   <= req_next;
            stat_reg  <= stat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        free_reg  <= free_next;
        cur_reg   <= cur_next;
        id_reg    <= id_next;
        wake_reg  <= wake_next;
        wraps_reg <= wraps_next;
        now_reg   <= now_next;
        en_reg    <= en_next;
        val_reg   <= val_next;
    end

    // one valid bit per slot; the count of set bits tracks cnt_reg
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_WAITERS; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (valid_set)
        begin
            valid_reg[valid_idx] <= 1'b1;
        end
        else if (valid_clr)
        begin
            valid_reg[valid_idx] <= 1'b0;
        end
    end

    // result register: load a beat when the slot is free, drop it when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_user_reg <= !out_woken;
            out_last_reg <= !out_woken;
            out_id_reg   <= out_woken ? slot_q.proc : 8'd0;
            out_stat_reg <= out_woken ? ST_OK : stat_reg;
            out_upd_reg  <= !out_woken && upd_calc;
            out_en_reg   <= !out_woken && upd_calc && en_reg;
            out_val_reg  <= (!out_woken && upd_calc) ? val_reg : 32'd0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {4'd0, out_val_reg, out_en_reg, out_upd_reg, out_stat_reg, out_id_reg};

    // ---------------------------------------------------------------- checks
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_MAX)
        else $error("entry count above capacity");

    a_last_is_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == m_tuser))
        else $error("last beat and status beat disagree");

    a_upd_on_status: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[10]) |-> m_tuser)
        else $error("timer update on a woken beat");

    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second request taken while one is at work");

endmodule

@@ rtl/swtq_ram.sv @@
// ----------------------------------------------------------------------------
// swtq_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module swtq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // hold read data when no read is issued
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
